@@ src/sha256_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha-256 package
// round constants, initial chaining values, padding constants and the stream action code
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned Rounds = 64;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned PadLenOffset = 56;
  localparam logic [7:0] PadByte = 8'h80;

  typedef enum logic {
    ACT_ABSORB = 1'b0,
    ACT_FINISH = 1'b1
  } action_e;

  typedef logic [WordW-1:0] word_t;

  function automatic word_t round_const(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic word_t init_chain(input logic [2:0] idx);
    word_t h;
    case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
      default: h = '0;
    endcase
    return h;
  endfunction

endpackage

@@ src/sha256_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha-256 compression core
// one round per cycle; message schedule in a 16-word sliding window
// ----------------------------------------------------------------------------
module sha256_core import sha256_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [511:0] block_i,
  input  word_t       chain_i [8],
  output logic        done_o,
  output word_t       chain_o [8]
);

  word_t       w_q [16];
  word_t       v_q [8];
  logic [5:0]  rnd_q;
  logic        busy_q;
  logic        fold_q;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  word_t s0, s1, w_new, big0, big1, ch, maj, t1, t2;

  always_comb begin
    s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = w_q[0] + s0 + w_q[9] + s1;
    big1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1 = v_q[7] + big1 + ch + round_const(rnd_q) + w_q[0];
    big0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2 = big0 + maj;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fold_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      fold_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'(Rounds - 1)) begin
          busy_q <= 1'b0;
          fold_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      for (int i = 0; i < 16; i++) w_q[i] <= block_i[511 - 32*i -: 32];
      for (int i = 0; i < 8; i++) v_q[i] <= chain_i[i];
    end else if (busy_q) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign done_o = fold_q;
  always_comb begin
    for (int i = 0; i < 8; i++) chain_o[i] = chain_i[i] + v_q[i];
  end

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> (busy_q || fold_q)) else $error("core dropped out mid block");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fold_q |=> !fold_q) else $error("done held two cycles");
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fold_q |-> $past(busy_q)) else $error("done without a block");
`endif

endmodule

@@ src/sha256_stream_hasher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha-256 stream hasher
// byte-wide absorb and finish; digest out as four 64-bit parts
// ----------------------------------------------------------------------------
// channel | dir | tdata                    | tuser      | tlast
// s_axis  | in  | data_byte[7:0]           | action     | -
// m_axis  | out | digest_part[63:0]        | part_index | last_part
// an absorb transfer that fills a block starts a compression (64 rounds)
// a finish transfer pads one byte a cycle, pausing while a full block compresses, and runs one or two compressions
// the four digest parts follow, each held until taken
// s_axis_tready is low while padding, compressing or emitting
// ----------------------------------------------------------------------------
module sha256_stream_hasher import sha256_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // digest_part
  output logic [1:0]  m_axis_tuser,   // part_index
  output logic        m_axis_tlast    // last_part
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_COMP, ST_PAD, ST_LEN, ST_EMIT
  } state_e;

  state_e      state_q;
  logic [511:0] blk_q;
  logic [5:0]  fill_q;
  logic [63:0] msg_q;
  logic [63:0] bits_q;
  logic        fin_q;
  logic [1:0]  part_q;
  word_t       chain_q [8];
  word_t       chain_new [8];
  logic        core_start, core_done;
  logic [511:0] block_flat;
  logic        push;
  logic [7:0]  push_byte;

  // byte 0 of the block sits in the top bits; the byte pushed now closes it
  assign block_flat = {blk_q[503:0], push_byte};

  sha256_core u_core (
    .clk_i, .rst_ni,
    .start_i(core_start), .block_i(block_flat), .chain_i(chain_q),
    .done_o(core_done), .chain_o(chain_new)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  wire in_xfer = s_axis_tvalid && s_axis_tready;

  always_comb begin
    push = 1'b0;
    push_byte = 8'h00;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          push = 1'b1;
          push_byte = (s_axis_tuser == ACT_FINISH) ? PadByte : s_axis_tdata;
        end
      end
      ST_PAD: push = 1'b1;
      ST_LEN: begin
        push = 1'b1;
        push_byte = bits_q[63:56];
      end
      default: push = 1'b0;
    endcase
  end

  assign core_start = push && (fill_q == 6'(BlockBytes - 1));

  always_ff @(posedge clk_i) begin
    if (push) blk_q <= {blk_q[503:0], push_byte};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      msg_q   <= '0;
      bits_q  <= '0;
      fin_q   <= 1'b0;
      part_q  <= '0;
      for (int i = 0; i < 8; i++) chain_q[i] <= init_chain(3'(i));
    end else begin
      if (push) fill_q <= fill_q + 6'd1;
      if (state_q == ST_LEN && push) bits_q <= {bits_q[55:0], 8'h00};
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (s_axis_tuser == ACT_FINISH) begin
              fin_q  <= 1'b1;
              bits_q <= {msg_q[60:0], 3'b000};
            end else begin
              msg_q <= msg_q + 64'd1;
            end
            if (core_start) state_q <= ST_COMP;
            else if (s_axis_tuser == ACT_FINISH) begin
              state_q <= (fill_q + 6'd1 == 6'(PadLenOffset)) ? ST_LEN : ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (core_start) state_q <= ST_COMP;
          else if (fill_q + 6'd1 == 6'(PadLenOffset)) state_q <= ST_LEN;
        end
        ST_LEN: begin
          if (core_start) state_q <= ST_COMP;
        end
        ST_COMP: begin
          if (core_done) begin
            for (int i = 0; i < 8; i++) chain_q[i] <= chain_new[i];
            // length bytes all shifted out means the closing block is done
            if (!fin_q) state_q <= ST_IDLE;
            else if (bits_q == '0) state_q <= ST_EMIT;
            else state_q <= ST_PAD;
          end
        end
        ST_EMIT: begin
          if (m_axis_tready) begin
            part_q <= part_q + 2'd1;
            if (part_q == 2'd3) begin
              state_q <= ST_IDLE;
              fin_q   <= 1'b0;
              msg_q   <= '0;
              fill_q  <= '0;
              for (int i = 0; i < 8; i++) chain_q[i] <= init_chain(3'(i));
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = (state_q == ST_EMIT);
  assign m_axis_tdata  = {chain_q[{part_q, 1'b0}], chain_q[{part_q, 1'b1}]};
  assign m_axis_tuser  = part_q;
  assign m_axis_tlast  = (part_q == 2'd3);

`ifndef SYNTHESIS
  a_emit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("digest parts broken up");
  a_idle_part: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (part_q == 2'd0)) else $error("part count not cleared");
  a_emit_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (fill_q == '0)) else $error("emit with buffered bytes");
`endif

endmodule

@@ dv/tb_sha256_stream_hasher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha-256 stream hasher testbench
// streams messages of absorb transfers closed by a finish transfer, predicts
// the digest parts with a behavioural sha-256 and checks every output transfer
// in order; both sides idle in random bursts except in the closing stretch
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher;
  import sha256_pkg::*;

  typedef struct packed {
    action_e    act;
    logic [7:0] data;
  } byte_item_t;

  typedef struct packed {
    logic [63:0] part;
    logic [1:0]  idx;
    logic        last;
  } digest_part_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  byte_item_t   pending_q[$];
  digest_part_t digest_q[$];
  int unsigned  errors = 0;
  bit           calm = 1'b0;
  bit           hold_tx = 1'b0;
  bit           in_taken = 1'b0;

  // predictor state
  logic [31:0] chain[8];
  logic [7:0]  blk[64];
  logic [5:0]  fill;
  logic [63:0] msg_len;

  always #1 clk_i = ~clk_i;

  sha256_stream_hasher u_top (.*);

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hash_reset();
    chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    fill = '0;
    msg_len = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
           + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    v = chain;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const(i[5:0]) + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endfunction

  function automatic void buffer_byte(logic [7:0] b);
    blk[fill] = b;
    fill++;
    if (fill == 0) compress_block();
  endfunction

  function automatic void hash_item(byte_item_t it);
    logic [63:0] bits;
    digest_part_t d;
    if (it.act == ACT_ABSORB) begin
      msg_len++;
      buffer_byte(it.data);
    end else begin
      bits = msg_len << 3;
      buffer_byte(PadByte);
      while (fill != PadLenOffset) buffer_byte(8'h00);
      for (int i = 7; i >= 0; i--) buffer_byte(bits[8*i +: 8]);
      for (int k = 0; k < 4; k++) begin
        d.part = {chain[2*k], chain[2*k+1]};
        d.idx  = k[1:0];
        d.last = (k == 3);
        digest_q.push_back(d);
      end
      hash_reset();
    end
  endfunction

  function automatic void add_message(int len, int fill_kind);
    byte_item_t it;
    for (int i = 0; i < len; i++) begin
      it.act = ACT_ABSORB;
      case (fill_kind)
        0: it.data = 8'h00;
        1: it.data = 8'hff;
        default: it.data = 8'($urandom_range(0, 255));
      endcase
      pending_q.push_back(it);
    end
    it.act = ACT_FINISH;
    it.data = 8'($urandom_range(0, 255));
    pending_q.push_back(it);
  endfunction

  // input transfers seen at the rising edge
  always @(posedge clk_i) begin
    in_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
  end

  // driver
  int unsigned tx_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (tx_gap != 0) tx_gap--;
      if (in_taken) begin
        hash_item(pending_q.pop_front());
        if (!calm && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 18);
      end
      if (tx_gap == 0 && !hold_tx && pending_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_q[0].data;
        s_axis_tuser  <= pending_q[0].act;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver stalls and checking
  int unsigned rx_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_gap != 0) rx_gap--;
      else if (!calm && $urandom_range(0, 7) == 0) rx_gap = $urandom_range(1, 18);
      m_axis_tready <= (rx_gap == 0);
    end
  end

  always @(posedge clk_i) begin
    digest_part_t exp_d;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected transfer data %h user %0d last %0b", $time,
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        exp_d = digest_q.pop_front();
        if (m_axis_tdata !== exp_d.part) begin
          $display("%0t: digest part exp %h got %h", $time, exp_d.part, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== exp_d.idx) begin
          $display("%0t: part index exp %0d got %0d", $time, exp_d.idx, m_axis_tuser);
          errors++;
        end
        if (m_axis_tlast !== exp_d.last) begin
          $display("%0t: last exp %0b got %0b", $time, exp_d.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    hash_reset();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // empty message, pad boundaries, all-zero and all-one bytes
    add_message(0, 2);
    add_message(55, 0);
    add_message(56, 1);
    add_message(63, 2);
    add_message(64, 1);
    wait (pending_q.size() == 0 && digest_q.size() == 0);

    // sender is held off while the next message is queued, then released
    hold_tx = 1'b1;
    add_message(3, 2);
    @(negedge clk_i);
    hold_tx = 1'b0;

    // random messages, mostly short, a few spanning several blocks
    for (int n = 0; n < 250;) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 140) : $urandom_range(0, 20);
      add_message(len, 2);
      n += len + 1;
    end
    wait (pending_q.size() < 60);
    calm = 1'b1;
    wait (pending_q.size() == 0 && digest_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && digest_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/sha256_pkg.sv
src/sha256_core.sv
src/sha256_stream_hasher.sv
dv/tb_sha256_stream_hasher.sv
